// ===== rtl/pb64_pkg.sv =====
package pb64_pkg;

    typedef enum logic [1:0]
    {
        CLS_SPACE,
        CLS_SYMBOL,
        CLS_PAD,
        CLS_ILLEGAL
    } char_class_t;

    typedef struct packed
    {
        char_class_t cls;
        logic [5:0]  sym;
    } sym_info_t;

    localparam logic [7:0] ASCII_SPACE   = 8'h20;
    localparam logic [7:0] ASCII_PLUS    = 8'h2B;
    localparam logic [7:0] ASCII_SLASH   = 8'h2F;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_NINE    = 8'h39;
    localparam logic [7:0] ASCII_PAD     = 8'h3D;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;

    localparam logic [5:0] SYM_LOWER_BASE = 6'd26;
    localparam logic [5:0] SYM_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SYM_PLUS       = 6'd62;
    localparam logic [5:0] SYM_SLASH      = 6'd63;

    localparam int         DONE_COUNT_BITS = 16;
    localparam logic [2:0] PEND_FULL       = 3'd6;
    localparam logic [2:0] BYTE_SPILL      = 3'd2;

endpackage

// ===== rtl/pem_base64_body_decoder.sv =====
// A result is registered and valid in the cycle after its input transaction is accepted.
// Throughput: one character per cycle; the single result register stalls the
// input only while a result is held and out_stall is high.
// Reset (rst_n low, asynchronous) clears the accumulator, pad and error flags,
// the byte counter and the result valid flag.
module pem_base64_body_decoder
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_char,
    input  logic        body_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        byte_valid,
    output logic [7:0]  data_byte,
    output logic        decode_error,
    output logic        record_done,
    output logic [15:0] decoded_count
);
    import pb64_pkg::*;

    sym_info_t              info;
    logic                   accept_in;

    logic [5:0]             acc_reg;
    logic [5:0]             acc_next;
    logic [2:0]             pend_reg;
    logic [2:0]             pend_next;
    logic                   pad_reg;
    logic                   pad_next;
    logic                   err_reg;
    logic                   err_next;
    logic [COUNT_BITS-1:0]  cnt_reg;
    logic [COUNT_BITS-1:0]  cnt_next;
    logic [COUNT_BITS-1:0]  cnt_step;

    logic [11:0]            merged;
    logic [2:0]             pend_left;
    logic                   step_byte_valid;
    logic [7:0]             step_data_byte;
    logic [DONE_COUNT_BITS-1:0] count_sat;

    logic                   out_valid_reg;
    logic                   byte_valid_reg;
    logic [7:0]             data_byte_reg;
    logic                   decode_error_reg;
    logic                   record_done_reg;
    logic [15:0]            decoded_count_reg;

    pb64_char_map u_char_map
    (
        .ch   (in_char),
        .info (info)
    );

    assign in_stall  = out_valid_reg && out_stall;
    assign accept_in = in_valid && !in_stall;

    assign merged    = {acc_reg, info.sym};
    assign pend_left = pend_reg - BYTE_SPILL;

    always_comb
    begin
        acc_next        = acc_reg;
        pend_next       = pend_reg;
        pad_next        = pad_reg;
        err_next        = err_reg;
        cnt_step        = cnt_reg;
        step_byte_valid = 1'b0;
        step_data_byte  = '0;
        if (!err_reg && info.cls != CLS_SPACE)
        begin
            if (pad_reg)
            begin
                if (info.cls != CLS_PAD)
                begin
                    err_next = 1'b1;
                end
            end
            else
            begin
                case (info.cls)
                    CLS_PAD:
                    begin
                        pad_next = 1'b1;
                    end
                    CLS_SYMBOL:
                    begin
                        if (pend_reg == 3'd0)
                        begin
                            acc_next  = info.sym;
                            pend_next = PEND_FULL;
                        end
                        else
                        begin
                            acc_next        = merged[5:0];
                            pend_next       = pend_left;
                            step_byte_valid = 1'b1;
                            step_data_byte  = 8'(merged >> pend_left);
                            if (cnt_reg != {COUNT_BITS{1'b1}})
                            begin
                                cnt_step = cnt_reg + COUNT_BITS'(1);
                            end
                        end
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
        end
        cnt_next = cnt_step;
    end

    generate
        if (COUNT_BITS > DONE_COUNT_BITS)
        begin : g_wide_count
            assign count_sat = (|cnt_step[COUNT_BITS-1:DONE_COUNT_BITS]) ?
                               {DONE_COUNT_BITS{1'b1}} : cnt_step[DONE_COUNT_BITS-1:0];
        end
        else
        begin : g_narrow_count
            assign count_sat = DONE_COUNT_BITS'(cnt_step);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            pend_reg <= '0;
            pad_reg  <= 1'b0;
            err_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (accept_in)
        begin
            if (body_end)
            begin
                acc_reg  <= '0;
                pend_reg <= '0;
                pad_reg  <= 1'b0;
                err_reg  <= 1'b0;
                cnt_reg  <= '0;
            end
            else
            begin
                acc_reg  <= acc_next;
                pend_reg <= pend_next;
                pad_reg  <= pad_next;
                err_reg  <= err_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept_in)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            byte_valid_reg    <= step_byte_valid;
            data_byte_reg     <= step_data_byte;
            decode_error_reg  <= err_next;
            record_done_reg   <= body_end;
            decoded_count_reg <= (body_end && !err_next) ? count_sat : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_valid    = byte_valid_reg;
    assign data_byte     = data_byte_reg;
    assign decode_error  = decode_error_reg;
    assign record_done   = record_done_reg;
    assign decoded_count = decoded_count_reg;

    a_pend_even: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_reg[0] && pend_reg != 3'd7)
        else $error("pending bit count is not 0, 2, 4 or 6");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && body_end) |=>
            (pend_reg == 3'd0 && !pad_reg && !err_reg && cnt_reg == '0))
        else $error("record end did not clear decoder state");

    a_no_byte_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_valid) |-> !decode_error)
        else $error("byte emitted with error flag set");

    a_count_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !record_done) |-> (decoded_count == '0))
        else $error("byte count reported before record end");

    a_no_byte_after_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && pad_reg) |=> !byte_valid)
        else $error("byte emitted after padding");

endmodule

// ===== rtl/pb64_char_map.sv =====
module pb64_char_map
(
    input  logic [7:0]           ch,
    output pb64_pkg::sym_info_t  info
);
    import pb64_pkg::*;

    always_comb
    begin
        info.cls = CLS_ILLEGAL;
        info.sym = '0;
        case (ch) inside
            [8'h00:ASCII_SPACE]:
            begin
                info.cls = CLS_SPACE;
            end
            [ASCII_UPPER_A:ASCII_UPPER_Z]:
            begin
                info.cls = CLS_SYMBOL;
                info.sym = 6'(ch - ASCII_UPPER_A);
            end
            [ASCII_LOWER_A:ASCII_LOWER_Z]:
            begin
                info.cls = CLS_SYMBOL;
                info.sym = 6'(ch - ASCII_LOWER_A) + SYM_LOWER_BASE;
            end
            [ASCII_ZERO:ASCII_NINE]:
            begin
                info.cls = CLS_SYMBOL;
                info.sym = 6'(ch - ASCII_ZERO) + SYM_DIGIT_BASE;
            end
            ASCII_PLUS:
            begin
                info.cls = CLS_SYMBOL;
                info.sym = SYM_PLUS;
            end
            ASCII_SLASH:
            begin
                info.cls = CLS_SYMBOL;
                info.sym = SYM_SLASH;
            end
            ASCII_PAD:
            begin
                info.cls = CLS_PAD;
            end
            default:
            begin
                info.cls = CLS_ILLEGAL;
            end
        endcase
    end

endmodule

// ===== tb/sv/pem_base64_body_decoder_tb.sv =====
module pem_base64_body_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pb64_pkg::*;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 8;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int LONG_HOLD        = 64;
    localparam int DRAIN_CYCLES     = 4;
    localparam int PHASE_ITEMS      = 170;
    localparam int MAX_PRINTED      = 40;
    localparam int DIRECTED_ROWS    = 25;

    typedef struct packed
    {
        logic        byte_valid;
        logic [7:0]  data_byte;
        logic        decode_error;
        logic        record_done;
        logic [15:0] decoded_count;
    } decode_result_t;

    typedef struct
    {
        logic [7:0]     ch;
        logic           last;
        logic           typed;
        decode_result_t want;
    } stim_row_t;

    localparam decode_result_t QUIET    = '0;
    localparam decode_result_t ERR_SET  = '{1'b0, 8'h00, 1'b1, 1'b0, 16'h0000};
    localparam decode_result_t ERR_DONE = '{1'b0, 8'h00, 1'b1, 1'b1, 16'h0000};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  in_char   = '0;
    logic        body_end  = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        byte_valid;
    logic [7:0]  data_byte;
    logic        decode_error;
    logic        record_done;
    logic [15:0] decoded_count;

    // decoder state as predicted
    logic [11:0] acc_bits     = '0;
    logic [2:0]  acc_count    = '0;
    logic        pad_seen     = 1'b0;
    logic        err_latched  = 1'b0;
    logic [15:0] bytes_out    = '0;

    decode_result_t pending_results [$];
    decode_result_t oldest;

    int          tx_idle_pct  = 0;
    int          rx_idle_pct  = 0;
    int          holds_asked  = 0;
    int          holds_served = 0;
    int          items_sent   = 0;
    int          mismatches   = 0;
    int          cycle_count  = 0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{"T",         1'b0, 1'b1, QUIET},
        '{"W",         1'b0, 1'b1, '{1'b1, 8'h4D, 1'b0, 1'b0, 16'h0000}},
        '{8'h0A,       1'b0, 1'b1, QUIET},
        '{"F",         1'b0, 1'b0, QUIET},
        '{"u",         1'b0, 1'b0, QUIET},
        '{ASCII_SLASH, 1'b0, 1'b0, QUIET},
        '{ASCII_PLUS,  1'b0, 1'b0, QUIET},
        '{"A",         1'b0, 1'b0, QUIET},
        '{"Z",         1'b0, 1'b0, QUIET},
        '{"z",         1'b0, 1'b0, QUIET},
        '{"0",         1'b0, 1'b0, QUIET},
        '{"9",         1'b0, 1'b0, QUIET},
        '{ASCII_PAD,   1'b0, 1'b0, QUIET},
        '{ASCII_PAD,   1'b0, 1'b0, QUIET},
        '{ASCII_SPACE, 1'b1, 1'b0, QUIET},
        '{"Q",         1'b0, 1'b1, QUIET},
        '{8'h00,       1'b0, 1'b1, QUIET},
        '{"!",         1'b0, 1'b1, ERR_SET},
        '{"A",         1'b0, 1'b1, ERR_SET},
        '{8'hFF,       1'b1, 1'b1, ERR_DONE},
        '{"Q",         1'b0, 1'b0, QUIET},
        '{ASCII_PAD,   1'b0, 1'b0, QUIET},
        '{"Q",         1'b0, 1'b1, ERR_SET},
        '{ASCII_SPACE, 1'b1, 1'b1, ERR_DONE},
        '{"A",         1'b1, 1'b0, QUIET}
    };

    pem_base64_body_decoder uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_char       (in_char),
        .body_end      (body_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .byte_valid    (byte_valid),
        .data_byte     (data_byte),
        .decode_error  (decode_error),
        .record_done   (record_done),
        .decoded_count (decoded_count)
    );

    always #CLK_HALF clk = ~clk;

    function automatic sym_info_t classify(input logic [7:0] c);
        sym_info_t info;
        info.sym = '0;
        info.cls = CLS_ILLEGAL;
        if (c <= ASCII_SPACE)
        begin
            info.cls = CLS_SPACE;
        end
        else if (c == ASCII_PAD)
        begin
            info.cls = CLS_PAD;
        end
        else if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z)
        begin
            info.cls = CLS_SYMBOL;
            info.sym = 6'(c - ASCII_UPPER_A);
        end
        else if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z)
        begin
            info.cls = CLS_SYMBOL;
            info.sym = SYM_LOWER_BASE + 6'(c - ASCII_LOWER_A);
        end
        else if (c >= ASCII_ZERO && c <= ASCII_NINE)
        begin
            info.cls = CLS_SYMBOL;
            info.sym = SYM_DIGIT_BASE + 6'(c - ASCII_ZERO);
        end
        else if (c == ASCII_PLUS)
        begin
            info.cls = CLS_SYMBOL;
            info.sym = SYM_PLUS;
        end
        else if (c == ASCII_SLASH)
        begin
            info.cls = CLS_SYMBOL;
            info.sym = SYM_SLASH;
        end
        return info;
    endfunction

    function automatic logic [7:0] symbol_char(input logic [5:0] s);
        if (s < SYM_LOWER_BASE)
            return ASCII_UPPER_A + 8'(s);
        else if (s < SYM_DIGIT_BASE)
            return ASCII_LOWER_A + 8'(s - SYM_LOWER_BASE);
        else if (s < SYM_PLUS)
            return ASCII_ZERO + 8'(s - SYM_DIGIT_BASE);
        else if (s == SYM_PLUS)
            return ASCII_PLUS;
        return ASCII_SLASH;
    endfunction

    function automatic logic [7:0] illegal_char();
        logic [7:0] c;
        sym_info_t  info;
        c    = 8'($urandom_range(8'h21, 8'hFF));
        info = classify(c);
        while (info.cls != CLS_ILLEGAL)
        begin
            c    = 8'($urandom_range(8'h21, 8'hFF));
            info = classify(c);
        end
        return c;
    endfunction

    function automatic decode_result_t decode_char(input logic [7:0] c, input logic last);
        sym_info_t      info;
        decode_result_t r;
        logic [3:0]     bits;
        info = classify(c);
        r    = '0;
        if (!err_latched && info.cls != CLS_SPACE)
        begin
            if (pad_seen)
            begin
                if (info.cls != CLS_PAD)
                    err_latched = 1'b1;
            end
            else if (info.cls == CLS_PAD)
            begin
                pad_seen = 1'b1;
            end
            else if (info.cls == CLS_ILLEGAL)
            begin
                err_latched = 1'b1;
            end
            else
            begin
                acc_bits = {acc_bits[5:0], info.sym};
                bits     = 4'(acc_count) + 4'd6;
                if (bits >= 4'd8)
                begin
                    bits        = bits - 4'd8;
                    r.byte_valid = 1'b1;
                    r.data_byte  = 8'(acc_bits >> bits);
                    acc_bits     = acc_bits & ((12'd1 << bits) - 12'd1);
                    if (bytes_out != '1)
                        bytes_out = bytes_out + 16'd1;
                end
                acc_count = bits[2:0];
            end
        end
        r.decode_error = err_latched;
        r.record_done  = last;
        if (last)
        begin
            if (!err_latched)
                r.decoded_count = bytes_out;
            acc_bits    = '0;
            acc_count   = '0;
            pad_seen    = 1'b0;
            err_latched = 1'b0;
            bytes_out   = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch on %s: got %0h, expected %0h, cycle %0d",
                     what, got, want, cycle_count);
    endtask

    task automatic send_char(input logic [7:0] c, input logic last,
                             input logic typed = 1'b0, input decode_result_t want = '0);
        decode_result_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        body_end <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = decode_char(c, last);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_record();
        logic [7:0] body [$];
        int         kind;
        int         n_sym;
        int         n_pad;
        int         i;
        kind  = $urandom_range(0, 9);
        n_sym = $urandom_range(1, 20);
        n_pad = (kind == 8) ? $urandom_range(1, 2) : $urandom_range(0, 2);
        for (i = 0; i < n_sym; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                body.push_back(8'($urandom_range(0, 32)));
            body.push_back(symbol_char(6'($urandom_range(0, 63))));
        end
        for (i = 0; i < n_pad; i++)
            body.push_back(ASCII_PAD);
        if (kind == 7)
            body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
        else if (kind == 8)
            body.push_back(symbol_char(6'($urandom_range(0, 63))));
        else if (kind == 9)
            body.insert($urandom_range(0, body.size()), illegal_char());
        if ($urandom_range(0, 3) == 0)
            body.push_back(8'($urandom_range(0, 32)));
        for (i = 0; i < body.size(); i++)
            send_char(body[i], i == body.size() - 1);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input bit long_hold);
        int target;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target      = items_sent + PHASE_ITEMS;
        if (long_hold)
        begin
            send_random_record();
            holds_asked++;
        end
        while (items_sent < target)
            send_random_record();
        in_valid <= 1'b0;
        drain_results();
    endtask

    initial
    begin
        int held;
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                out_stall <= 1'b1;
                for (held = 1; held < LONG_HOLD; held++)
                    @(posedge clk);
                holds_served++;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected transaction", 1, 0);
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (byte_valid !== oldest.byte_valid)
                    report_mismatch("byte_valid", byte_valid, oldest.byte_valid);
                if (data_byte !== oldest.data_byte)
                    report_mismatch("data_byte", data_byte, oldest.data_byte);
                if (decode_error !== oldest.decode_error)
                    report_mismatch("decode_error", decode_error, oldest.decode_error);
                if (record_done !== oldest.record_done)
                    report_mismatch("record_done", record_done, oldest.record_done);
                if (decoded_count !== oldest.decoded_count)
                    report_mismatch("decoded_count", decoded_count, oldest.decoded_count);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int i;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
            send_char(directed_rows[i].ch, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);
        in_valid <= 1'b0;
        drain_results();

        run_phase(13, 75, 1'b1);
        run_phase(75, 13, 1'b0);
        run_phase(0, 0, 1'b1);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
